FILE: sv/wmo_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wavetable mix oscillator package
// Shared widths, item types, register indexes and job format used by the
// front end, the job queue, the mixing back end and the top level.
// ---------------------------------------------------------------------------
package wmo_pkg;

    // Table geometry and sample format
    localparam int TABLE_LENGTH  = 1024;
    localparam int IDX_BITS      = $clog2(TABLE_LENGTH);
    localparam int MAX_TABLES    = 4;
    localparam int SAMPLE_BITS   = 16;
    localparam int PHASE_BITS    = 32;
    localparam int FRAC_BITS     = PHASE_BITS - IDX_BITS;
    localparam int SEL_BITS      = 2;

    // Mix weights, signed Q2.14
    localparam int WEIGHT_BITS   = 16;
    localparam int WEIGHT_FRAC   = 14;
    localparam int WEIGHT_REGS   = 4;
    localparam int ACTIVE_BITS   = 3;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Depth of the queue between front end and back end (power of two)
    localparam int JOB_DEPTH     = 2;

    // Datapath widths of the interpolate and mix pipeline
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + FRAC_BITS + 1;
    localparam int INTERP_BITS   = PROD_BITS;
    localparam int WTD_BITS      = INTERP_BITS + WEIGHT_BITS;
    localparam int ACC_BITS      = WTD_BITS + $clog2(WEIGHT_REGS);
    localparam int SUM_BITS      = ACC_BITS + 1;
    localparam int ROUND_SHIFT   = FRAC_BITS + WEIGHT_FRAC;

    // Register indexes of the configuration port
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    localparam t_cfg_index CFG_PHASE_INC = 3'd0;
    localparam t_cfg_index CFG_ACTIVE    = 3'd1;
    localparam t_cfg_index CFG_WEIGHT_0  = 3'd2;
    localparam t_cfg_index CFG_WEIGHT_1  = 3'd3;
    localparam t_cfg_index CFG_WEIGHT_2  = 3'd4;
    localparam t_cfg_index CFG_WEIGHT_3  = 3'd5;

    // Request kinds
    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_WRITE = 1'b1
    } t_kind;

    // One input request
    typedef struct packed {
        t_kind                          kind;
        logic [SEL_BITS-1:0]            table_select;
        logic [IDX_BITS-1:0]            table_address;
        logic signed [SAMPLE_BITS-1:0]  table_value;
    } t_in_item;

    // One result
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  mixed_sample;
        logic                           clipped;
    } t_out_item;

    // Classified job handed from the front end to the back end.
    // For a tick, addr is the table index and frac the phase fraction.
    typedef struct packed {
        t_kind                          kind;
        logic [SEL_BITS-1:0]            sel;
        logic [IDX_BITS-1:0]            addr;
        logic [SAMPLE_BITS-1:0]         value;
        logic [FRAC_BITS-1:0]           frac;
    } t_job;

    // Mixing configuration seen by the back end
    typedef struct packed {
        logic [ACTIVE_BITS-1:0]                   active;
        logic [WEIGHT_REGS-1:0][WEIGHT_BITS-1:0]  weight;
    } t_mix_cfg;

endpackage
`default_nettype wire

FILE: sv/wmo_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wavetable mix oscillator RAM
// Generic memory with one write port and two read ports, registered reads.
// ---------------------------------------------------------------------------
module wmo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr_b,
    output logic      [WIDTH-1:0]          o_rdata_a,
    output logic      [WIDTH-1:0]          o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

FILE: sv/wmo_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wavetable mix oscillator front end
// Accepts requests, drops table writes outside the table range, and turns
// each tick into a job carrying the table index and phase fraction while
// advancing the phase accumulator.
// ---------------------------------------------------------------------------
module wmo_front #(
    parameter int MAX_TABLES = wmo_pkg::MAX_TABLES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [wmo_pkg::PHASE_BITS-1:0]      i_phase_inc,
    input  wire logic                                i_push,
    input  wire wmo_pkg::t_in_item                   i_item,
    input  wire logic                                i_full,
    output logic                                     o_q_push,
    output wmo_pkg::t_job                            o_q_job
);
    import wmo_pkg::*;

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic                  w_accept;
    logic                  w_in_range;

    assign w_accept   = i_push && !i_full;
    assign w_in_range = int'(i_item.table_select) < MAX_TABLES;

    // Classify the request and build the job
    always_comb begin
        o_q_push = 1'b0;
        n_phase  = r_phase;
        o_q_job  = '0;
        o_q_job.kind = i_item.kind;
        case (i_item.kind)
            KIND_WRITE: begin
                o_q_job.sel   = i_item.table_select;
                o_q_job.addr  = i_item.table_address;
                o_q_job.value = i_item.table_value;
                o_q_push      = w_accept && w_in_range;
            end
            KIND_TICK: begin
                o_q_job.addr = r_phase[PHASE_BITS-1:FRAC_BITS];
                o_q_job.frac = r_phase[FRAC_BITS-1:0];
                o_q_push     = w_accept;
                if (w_accept) begin
                    // The span is a power of two, so the wrap is free.
                    n_phase = r_phase + i_phase_inc;
                end
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
    end

    // Phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

`ifndef ASSERT_OFF
    // A table write never moves the phase.
    a_write_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.kind == KIND_WRITE) |=> $stable(r_phase))
        else $error("phase changed on a table write");
`endif

endmodule
`default_nettype wire

FILE: sv/wmo_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wavetable mix oscillator job queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ---------------------------------------------------------------------------
module wmo_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire wmo_pkg::t_job  i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output wmo_pkg::t_job       o_job,
    output logic                o_empty
);
    import wmo_pkg::*;

    localparam int PTR_BITS = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(JOB_DEPTH + 1);

    t_job                r_slot [JOB_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_do_push;
    logic                w_do_pop;

    assign o_full    = r_count == CNT_BITS'(JOB_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_job     = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

FILE: sv/wmo_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wavetable mix oscillator back end
// Executes jobs in order: table writes go to the sample RAM, ticks read two
// neighboring samples per table, interpolate, weight and accumulate them,
// then round and saturate into the result register.
// ---------------------------------------------------------------------------
module wmo_back #(
    parameter int MAX_TABLES = wmo_pkg::MAX_TABLES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wmo_pkg::t_mix_cfg  i_cfg,
    input  wire logic               i_q_empty,
    input  wire wmo_pkg::t_job      i_q_job,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output wmo_pkg::t_out_item      o_result
);
    import wmo_pkg::*;

    localparam int DEPTH     = MAX_TABLES * TABLE_LENGTH;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int TAB_BITS  = $clog2(WEIGHT_REGS);
    localparam int LIMIT     = (MAX_TABLES < WEIGHT_REGS) ? MAX_TABLES : WEIGHT_REGS;
    localparam logic [ACTIVE_BITS-1:0] LIMIT_CODE = ACTIVE_BITS'(LIMIT);
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_back_state;

    t_back_state                    r_state;
    t_back_state                    n_state;
    logic [TAB_BITS-1:0]            r_t;
    logic [TAB_BITS-1:0]            n_t;
    logic [ACTIVE_BITS-1:0]         r_n;
    logic [IDX_BITS-1:0]            r_idx;
    logic [FRAC_BITS-1:0]           r_frac;
    logic                           r_v1;
    logic                           r_v2;
    logic                           r_v3;
    logic                           r_v4;
    logic signed [WEIGHT_BITS-1:0]  r_w1;
    logic signed [WEIGHT_BITS-1:0]  r_w2;
    logic signed [WEIGHT_BITS-1:0]  r_w3;
    logic signed [SAMPLE_BITS-1:0]  r_base;
    logic signed [PROD_BITS-1:0]    r_prod;
    logic signed [INTERP_BITS-1:0]  r_interp;
    logic signed [WTD_BITS-1:0]     r_wtd;
    logic signed [ACC_BITS-1:0]     r_acc;
    logic                           r_res_valid;
    t_out_item                      r_result;

    logic [ACTIVE_BITS-1:0]         w_n_eff;
    logic                           w_ram_we;
    logic                           w_start;
    logic                           w_finish;
    logic                           w_issue;
    logic                           w_take;
    logic                           w_busy;
    logic [IDX_BITS-1:0]            w_nxt;
    logic [ADDR_BITS-1:0]           w_waddr;
    logic [ADDR_BITS-1:0]           w_raddr_a;
    logic [ADDR_BITS-1:0]           w_raddr_b;
    logic [SAMPLE_BITS-1:0]         w_rd_a;
    logic [SAMPLE_BITS-1:0]         w_rd_b;
    logic signed [DIFF_BITS-1:0]    w_diff;
    logic signed [FRAC_BITS:0]      w_frac_s;
    logic signed [PROD_BITS-1:0]    w_prod;
    logic signed [INTERP_BITS-1:0]  w_interp;
    logic signed [WTD_BITS-1:0]     w_wtd;
    logic signed [SUM_BITS-1:0]     w_sum;
    logic signed [SUM_BITS-1:0]     w_y;
    t_out_item                      w_res;

    // Table count, capped at the number of tables and weight registers
    assign w_n_eff = (i_cfg.active > LIMIT_CODE) ? LIMIT_CODE : i_cfg.active;

    assign w_take  = i_pop && r_res_valid;
    assign w_busy  = r_v1 || r_v2 || r_v3 || r_v4;
    assign w_issue = r_state == ST_ISSUE;

    // Job sequencer
    always_comb begin
        n_state  = r_state;
        n_t      = r_t;
        o_q_pop  = 1'b0;
        w_ram_we = 1'b0;
        w_start  = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_job.kind == KIND_WRITE) begin
                        w_ram_we = 1'b1;
                    end else begin
                        w_start = 1'b1;
                        n_t     = '0;
                        n_state = (w_n_eff == '0) ? ST_FINISH : ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                n_t = r_t + TAB_BITS'(1);
                if (ACTIVE_BITS'(r_t) == r_n - ACTIVE_BITS'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_res_valid || i_pop) begin
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sample RAM: table number above the entry index
    assign w_nxt     = r_idx + IDX_BITS'(1);
    assign w_waddr   = ADDR_BITS'({i_q_job.sel, i_q_job.addr});
    assign w_raddr_a = ADDR_BITS'({r_t, r_idx});
    assign w_raddr_b = ADDR_BITS'({r_t, w_nxt});

    wmo_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   (w_waddr),
        .i_wdata   (i_q_job.value),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // Interpolation as a + (b - a) * f, then weighting
    assign w_diff   = DIFF_BITS'($signed(w_rd_b)) - DIFF_BITS'($signed(w_rd_a));
    assign w_frac_s = $signed({1'b0, r_frac});
    assign w_prod   = w_diff * w_frac_s;
    assign w_interp = (INTERP_BITS'(r_base) <<< FRAC_BITS) + r_prod;
    assign w_wtd    = r_interp * r_w3;

    // Round half up, then saturate
    assign w_sum = SUM_BITS'(r_acc) + ROUND_HALF;
    assign w_y   = w_sum >>> ROUND_SHIFT;

    always_comb begin
        if (w_y > SAT_HI) begin
            w_res.mixed_sample = SAT_HI[SAMPLE_BITS-1:0];
            w_res.clipped      = 1'b1;
        end else if (w_y < SAT_LO) begin
            w_res.mixed_sample = SAT_LO[SAMPLE_BITS-1:0];
            w_res.clipped      = 1'b1;
        end else begin
            w_res.mixed_sample = w_y[SAMPLE_BITS-1:0];
            w_res.clipped      = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_t         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            if (w_finish) begin
                r_res_valid <= 1'b1;
            end else if (w_take) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_n    <= w_n_eff;
            r_idx  <= i_q_job.addr;
            r_frac <= i_q_job.frac;
        end
        r_w1     <= $signed(i_cfg.weight[r_t]);
        r_w2     <= r_w1;
        r_w3     <= r_w2;
        r_base   <= $signed(w_rd_a);
        r_prod   <= w_prod;
        r_interp <= w_interp;
        r_wtd    <= w_wtd;
        if (w_start) begin
            r_acc <= '0;
        end else if (r_v4) begin
            r_acc <= r_acc + ACC_BITS'(r_wtd);
        end
        if (w_finish) begin
            r_result <= w_res;
        end
    end

    assign o_empty  = !r_res_valid;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    // Table writes only happen while no tick is in progress.
    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> r_state == ST_IDLE)
        else $error("table write during a tick");

    // The result is formed only after every table term reached the sum.
    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> !w_busy)
        else $error("result formed with terms still in flight");

    // Reads are issued only for tables that take part in the mix.
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (ACTIVE_BITS'(r_t) < r_n))
        else $error("read issued for a table beyond the mix");
`endif

endmodule
`default_nettype wire

FILE: sv/wavetable_mix_oscillator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Wavetable mix oscillator
// Phase accumulator wavetable oscillator with linear interpolation and a
// weighted, saturated mix of up to four sample tables.
// ---------------------------------------------------------------------------
// A push of a table write request stores one sample and gives no result; a
// push of a tick request gives one mixed sample and advances the phase. The
// front end takes one request per cycle, unless the queue is full, into a
// two-entry job queue. The back end runs jobs in order: a table write is
// stored as its job is taken; a tick takes the job, issues one two-sample
// RAM read per table per cycle, drains the read, interpolate and weight
// pipeline, sees it empty and forms the result once the result register is
// free (with no active table it skips the reads and the drain). A finished
// sample waits in the result register while the next jobs are taken. Ticks
// must only read table entries that were written since reset. Registers
// must be written only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module wavetable_mix_oscillator_top #(
    parameter int MAX_TABLES = wmo_pkg::MAX_TABLES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire wmo_pkg::t_cfg_index               i_cfg_index,
    input  wire logic [wmo_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire wmo_pkg::t_in_item                 i_item,
    output logic                                   empty,
    input  wire logic                              pop,
    output wmo_pkg::t_out_item                     o_result
);
    import wmo_pkg::*;

    logic [PHASE_BITS-1:0] r_phase_inc;
    t_mix_cfg              r_mix_cfg;
    logic                  w_q_push;
    t_job                  w_push_job;
    logic                  w_q_full;
    logic                  w_q_pop;
    t_job                  w_q_job;
    logic                  w_q_empty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_mix_cfg   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PHASE_INC: r_phase_inc <= i_cfg_data[PHASE_BITS-1:0];
                CFG_ACTIVE:    r_mix_cfg.active <= i_cfg_data[ACTIVE_BITS-1:0];
                CFG_WEIGHT_0:  r_mix_cfg.weight[0] <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_1:  r_mix_cfg.weight[1] <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_2:  r_mix_cfg.weight[2] <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_3:  r_mix_cfg.weight[3] <= i_cfg_data[WEIGHT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign full = w_q_full;

    // Front end: accept and classify
    wmo_front #(
        .MAX_TABLES (MAX_TABLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_phase_inc (r_phase_inc),
        .i_push      (push),
        .i_item      (i_item),
        .i_full      (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_job     (w_push_job)
    );

    // Job queue
    wmo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_job   (w_q_job),
        .o_empty (w_q_empty)
    );

    // Back end: table writes and mixing
    wmo_back #(
        .MAX_TABLES (MAX_TABLES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_mix_cfg),
        .i_q_empty (w_q_empty),
        .i_q_job   (w_q_job),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

FILE: sim/wavetable_mix_oscillator_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Wavetable mix oscillator regression
// Drives table write and tick requests through the push/full queue port and
// programs the mixing registers between phases. Every tick is predicted by a
// bit-exact model of interpolation, weighting, rounding and saturation, and
// each popped result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module wavetable_mix_oscillator_top_test;
    import wmo_pkg::*;

    localparam int RANDOM_ITEMS  = 1200;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    // Spare register indexes; the block must ignore writes to them.
    localparam t_cfg_index CFG_SPARE_A = 3'd6;
    localparam t_cfg_index CFG_SPARE_B = 3'd7;

    typedef struct {
        int        setting;
        t_in_item  req;
        bit        typed;
        t_out_item result;
    } t_directed_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    t_cfg_index               i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     push = 1'b0;
    logic                     full;
    t_in_item                 i_item = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    t_out_item                o_result;

    // Shadow of the oscillator state and mixing registers.
    logic [PHASE_BITS-1:0]         osc_phase = '0;
    logic [PHASE_BITS-1:0]         phase_step = '0;
    logic [ACTIVE_BITS-1:0]        mix_active = '0;
    logic signed [WEIGHT_BITS-1:0] mix_weight [WEIGHT_REGS];
    logic signed [SAMPLE_BITS-1:0] wave_mem [MAX_TABLES][TABLE_LENGTH];
    bit                            wave_valid [MAX_TABLES][TABLE_LENGTH];

    t_out_item     pending_samples [$];
    t_directed_row directed_rows [$];

    int feed_gap_max = 10;
    int drain_gap_max = 10;
    int sample_mismatches = 0;
    int samples_checked = 0;
    int samples_clipped = 0;
    int writes_sent = 0;
    int ticks_sent = 0;
    int settings_loaded = 0;

    wavetable_mix_oscillator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("wavetable_mix_oscillator_top regression: fail");
        $finish;
    end

    // Interpolate, weight and sum the active tables at the current phase,
    // round half up, saturate, then advance the phase.
    function automatic t_out_item next_mixed_sample();
        logic [IDX_BITS-1:0] idx;
        logic [IDX_BITS-1:0] nxt;
        longint              frac_f;
        longint              frac_g;
        longint              interp;
        longint              acc;
        longint              y;
        int                  n;
        t_out_item           r;
        idx    = osc_phase[PHASE_BITS-1:FRAC_BITS];
        nxt    = idx + 1'b1;
        frac_f = osc_phase[FRAC_BITS-1:0];
        frac_g = (longint'(1) << FRAC_BITS) - frac_f;
        n      = (mix_active > MAX_TABLES) ? MAX_TABLES : mix_active;
        acc    = 0;
        for (int t = 0; t < n; t++) begin
            interp = longint'(wave_mem[t][idx]) * frac_g
                   + longint'(wave_mem[t][nxt]) * frac_f;
            acc += interp * longint'(mix_weight[t]);
        end
        y = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        r.clipped = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.clipped = 1'b1;
        end
        if (y < -32768) begin
            y = -32768;
            r.clipped = 1'b1;
        end
        r.mixed_sample = y[SAMPLE_BITS-1:0];
        osc_phase = osc_phase + phase_step;
        return r;
    endfunction

    function automatic t_in_item table_write(input int sel, input int addr,
                                             input logic [SAMPLE_BITS-1:0] value);
        t_in_item it;
        it               = t_in_item'($urandom);
        it.kind          = KIND_WRITE;
        it.table_select  = sel[SEL_BITS-1:0];
        it.table_address = addr[IDX_BITS-1:0];
        it.table_value   = value;
        return it;
    endfunction

    // Tick requests carry random content in the fields they do not use.
    function automatic t_in_item tick_request();
        t_in_item it;
        it      = t_in_item'($urandom);
        it.kind = KIND_TICK;
        return it;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Weight data with random bits above the 16-bit register.
    function automatic logic [CFG_DATA_BITS-1:0] pick_weight();
        logic [15:0] w;
        case ($urandom_range(0, 7))
            0: w = 16'h7FFF;
            1: w = 16'h8000;
            2: w = 16'h4000;
            3: w = 16'hC000;
            4: w = 16'h0000;
            default: w = 16'($urandom);
        endcase
        return {16'($urandom), w};
    endfunction

    function automatic void add_row(input int setting, input t_in_item req,
                                    input bit typed, input logic [15:0] sample,
                                    input bit clip);
        t_directed_row row;
        row.setting             = setting;
        row.req                 = req;
        row.typed               = typed;
        row.result.mixed_sample = sample;
        row.result.clipped      = clip;
        directed_rows.push_back(row);
    endfunction

    task automatic note_mismatch(input string msg);
        sample_mismatches++;
        if (sample_mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // One register write; the shadow copy follows at once.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_PHASE_INC: phase_step = data;
            CFG_ACTIVE:    mix_active = data[ACTIVE_BITS-1:0];
            CFG_WEIGHT_0,
            CFG_WEIGHT_1,
            CFG_WEIGHT_2,
            CFG_WEIGHT_3:  mix_weight[idx - CFG_WEIGHT_0] = data[WEIGHT_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Program a full mix setting, including the spare indexes.
    task automatic program_mix(input logic [31:0] inc, input logic [31:0] active,
                               input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_PHASE_INC, inc);
        write_reg(CFG_ACTIVE, active);
        write_reg(CFG_WEIGHT_0, w0);
        write_reg(CFG_WEIGHT_1, w1);
        write_reg(CFG_WEIGHT_2, w2);
        write_reg(CFG_WEIGHT_3, w3);
        write_reg(CFG_SPARE_B, $urandom);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Push one request after a random gap and update the shadow on acceptance.
    task automatic send(input t_in_item req, input bit typed, input t_out_item typed_result);
        int        gap;
        t_out_item r;
        gap = $urandom_range(0, feed_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        if (req.kind == KIND_WRITE) begin
            wave_mem[req.table_select][req.table_address]   = req.table_value;
            wave_valid[req.table_select][req.table_address] = 1'b1;
            writes_sent++;
        end else begin
            r = next_mixed_sample();
            pending_samples.push_back(typed ? typed_result : r);
            ticks_sent++;
        end
        @(negedge i_clk);
    endtask

    // Wait until every sample is back, then let a trailing write job finish.
    task automatic settle();
        push <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Fill any unwritten entry the next tick would read, then send the tick.
    task automatic random_tick(inout int count);
        logic [IDX_BITS-1:0] idx;
        logic [IDX_BITS-1:0] a;
        int                  n;
        idx = osc_phase[PHASE_BITS-1:FRAC_BITS];
        n   = (mix_active > MAX_TABLES) ? MAX_TABLES : mix_active;
        for (int t = 0; t < n; t++) begin
            for (int k = 0; k < 2; k++) begin
                a = idx + IDX_BITS'(k);
                if (!wave_valid[t][a]) begin
                    send(table_write(t, a, pick_sample()), 1'b0, '0);
                    count++;
                end
            end
        end
        send(tick_request(), 1'b0, '0);
        count++;
    endtask

    // Result side: pop after random stalls and check against predictions.
    initial begin : result_check
        int        gap;
        t_out_item want;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, drain_gap_max);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            samples_checked++;
            if (o_result.clipped) samples_clipped++;
            if (pending_samples.size() == 0) begin
                note_mismatch($sformatf("sample %0d clipped %0b with none expected",
                                        o_result.mixed_sample, o_result.clipped));
            end else begin
                want = pending_samples.pop_front();
                if (o_result.mixed_sample !== want.mixed_sample)
                    note_mismatch($sformatf("mixed_sample expected %0d got %0d",
                                            want.mixed_sample, o_result.mixed_sample));
                if (o_result.clipped !== want.clipped)
                    note_mismatch($sformatf("clipped expected %0b got %0b",
                                            want.clipped, o_result.clipped));
            end
            @(negedge i_clk);
        end
    end

    // Request side: directed table, then random phases.
    initial begin : stimulus
        int            current_setting;
        int            random_count;
        int            phase_len;
        logic [31:0]   inc;
        t_directed_row row;
        foreach (mix_weight[i]) mix_weight[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full scale in and out at phase zero with unity weight.
        add_row(0, table_write(0, 0, 16'h7FFF), 1'b0, '0, 1'b0);
        add_row(0, table_write(0, 1, 16'h8000), 1'b0, '0, 1'b0);
        add_row(0, tick_request(), 1'b1, 16'h7FFF, 1'b0);
        add_row(0, table_write(0, 0, 16'h8000), 1'b0, '0, 1'b0);
        add_row(0, tick_request(), 1'b1, 16'h8000, 1'b0);
        // All tables, extreme weights, active count above the limit and the
        // largest increment, so the index wraps from the last entry to zero.
        for (int t = 1; t < MAX_TABLES; t++) begin
            add_row(1, table_write(t, 0, pick_sample()), 1'b0, '0, 1'b0);
            add_row(1, table_write(t, 1, pick_sample()), 1'b0, '0, 1'b0);
            add_row(1, table_write(t, TABLE_LENGTH - 1, pick_sample()), 1'b0, '0, 1'b0);
        end
        add_row(1, table_write(0, TABLE_LENGTH - 1, 16'h8000), 1'b0, '0, 1'b0);
        add_row(1, tick_request(), 1'b0, '0, 1'b0);
        add_row(1, tick_request(), 1'b0, '0, 1'b0);
        add_row(1, tick_request(), 1'b0, '0, 1'b0);
        // No active tables gives zero.
        add_row(2, tick_request(), 1'b1, 16'h0000, 1'b0);
        // Weight of -2.0 and nearly 2.0 on full negative scale saturate both ways.
        add_row(3, tick_request(), 1'b1, 16'h7FFF, 1'b1);
        add_row(4, tick_request(), 1'b1, 16'h8000, 1'b1);
        // Exact halves round toward plus infinity.
        add_row(5, table_write(0, TABLE_LENGTH - 1, 16'hFFFF), 1'b0, '0, 1'b0);
        add_row(5, table_write(0, 0, 16'hFFFF), 1'b0, '0, 1'b0);
        add_row(5, tick_request(), 1'b1, 16'h0000, 1'b0);
        add_row(5, table_write(0, TABLE_LENGTH - 1, 16'h0003), 1'b0, '0, 1'b0);
        add_row(5, table_write(0, 0, 16'h0003), 1'b0, '0, 1'b0);
        add_row(5, tick_request(), 1'b1, 16'h0002, 1'b0);

        current_setting = -1;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.setting != current_setting) begin
                settle();
                case (row.setting)
                    0: program_mix(32'h0, 32'd1, 32'h4000, 32'h0, 32'h0, 32'h0);
                    1: program_mix(32'hFFFF_FFFF, 32'd7, 32'h7FFF, 32'h8000,
                                   32'h4000, 32'hC000);
                    2: program_mix(32'h0, 32'd0, 32'h4000, 32'h4000, 32'h4000, 32'h4000);
                    3: program_mix(32'h0, 32'd1, 32'h8000, 32'h0, 32'h0, 32'h0);
                    4: program_mix(32'h0, 32'd1, 32'h7FFF, 32'h0, 32'h0, 32'h0);
                    default: program_mix(32'h0, 32'd1, 32'h2000, 32'h0, 32'h0, 32'h0);
                endcase
                current_setting = row.setting;
            end
            send(row.req, row.typed, row.result);
        end

        // Random phases, each with a fresh mix setting and idle profile.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            settle();
            feed_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
            drain_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            case ($urandom_range(0, 6))
                0: inc = 32'h0;
                1: inc = 32'hFFFF_FFFF;
                2: inc = $urandom_range(0, 1 << FRAC_BITS);
                3: inc = {10'($urandom_range(0, 3)), 22'h0};
                4: inc = {10'($urandom_range(1, 8)), 22'($urandom)};
                default: inc = $urandom;
            endcase
            program_mix(inc, {29'($urandom), 3'($urandom_range(0, 7))},
                        pick_weight(), pick_weight(), pick_weight(), pick_weight());
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len; i++) begin
                if ($urandom_range(0, 9) < 6) begin
                    random_tick(random_count);
                end else begin
                    // Writes land near the read position half of the time.
                    send(table_write($urandom_range(0, MAX_TABLES - 1),
                                     ($urandom_range(0, 1) == 0)
                                         ? int'(osc_phase[PHASE_BITS-1:FRAC_BITS])
                                           + $urandom_range(0, 3)
                                         : $urandom_range(0, TABLE_LENGTH - 1),
                                     pick_sample()),
                         1'b0, '0);
                    random_count++;
                end
            end
        end
        settle();

        $display("Run covered %0d table writes and %0d ticks under %0d mix settings.",
                 writes_sent, ticks_sent, settings_loaded);
        $display("Checked %0d samples, %0d of them clipped; %0d mismatches, %0d left over.",
                 samples_checked, samples_clipped, sample_mismatches,
                 pending_samples.size());
        if (sample_mismatches == 0 && pending_samples.size() == 0) begin
            $display("wavetable_mix_oscillator_top regression: pass");
        end else begin
            $display("wavetable_mix_oscillator_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/wmo_pkg.sv
sv/wmo_ram.sv
sv/wmo_front.sv
sv/wmo_queue.sv
sv/wmo_back.sv
sv/wavetable_mix_oscillator_top.sv
sim/wavetable_mix_oscillator_top_test.sv
